### src/mlfq_pkg.sv
`default_nettype none
package mlfq_pkg;

  localparam int unsigned OP_W = 3;
  localparam int unsigned TID_W = 5;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned SLICE_W = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLICE_LEFT_W = 18;

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_YIELD = 3'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 3'd2;
  localparam logic [OP_W-1:0] OP_EXIT = 3'd3;
  localparam logic [OP_W-1:0] OP_BLOCK = 3'd4;
  localparam logic [OP_W-1:0] OP_WAKE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_WAKE = 2'd2;

  localparam logic [1:0] RUN_READY = 2'd0;
  localparam logic [1:0] RUN_BLOCKED = 2'd1;
  localparam logic [1:0] RUN_EXITED = 2'd2;

  // One decoded request passed from the front end to the back end.
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [TID_W-1:0]     thread_id;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } req_t;

endpackage
`default_nettype wire

### src/mlfq_thread_scheduler.sv
// Channel  | Signals                                              | Flow
// config   | cfg_we, cfg_index, cfg_data                          | write, no wait
// request  | start, busy, op, thread_id, elapsed_ms               | start && !busy
// result   | done, running_tid, running_valid, switched,          | one-cycle strobe
//          | created_tid, grant_ms, status                        |
// From acceptance to its done strobe a request passes through the back end's update
// and, where needed, a choice, one queue memory read and the report.
// A two-entry request queue lets start be taken while the back end works.
// Reset is synchronous; after it thread 0 runs at level 0 with a full slice.
// The result receiver cannot stall; each result is shown for one cycle.
`default_nettype none
module mlfq_thread_scheduler #(
  parameter int unsigned LEVELS = 8,
  parameter int unsigned MAX_THREADS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [mlfq_pkg::SLICE_W-1:0]   cfg_data,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mlfq_pkg::OP_W-1:0]      op,
  input  wire logic [mlfq_pkg::TID_W-1:0]     thread_id,
  input  wire logic [mlfq_pkg::ELAPSED_W-1:0] elapsed_ms,
  output logic                               done,
  output logic [mlfq_pkg::TID_W-1:0]          running_tid,
  output logic                               running_valid,
  output logic                               switched,
  output logic [mlfq_pkg::TID_W-1:0]          created_tid,
  output logic [mlfq_pkg::SLICE_W-1:0]        grant_ms,
  output logic [mlfq_pkg::STATUS_W-1:0]       status
);

  logic                          policy_mode;
  logic [mlfq_pkg::SLICE_W-1:0]  slice_ms;
  logic                          req_valid;
  mlfq_pkg::req_t                req;
  logic                          req_take;
  logic                          back_idle;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= 1'b1;
      slice_ms <= mlfq_pkg::SLICE_W'(10);
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) policy_mode <= cfg_data[0];
      else slice_ms <= cfg_data;
    end
  end

  mlfq_front #(.QDEPTH(2)) u_front (
    .clk, .rst, .start, .op, .thread_id, .elapsed_ms,
    .busy, .req_valid, .req, .req_take
  );

  mlfq_back #(.LEVELS(LEVELS), .MAX_THREADS(MAX_THREADS)) u_back (
    .clk, .rst, .policy_mode, .slice_ms, .req_valid, .req, .req_take,
    .idle(back_idle), .done, .running_tid, .running_valid, .switched,
    .created_tid, .grant_ms, .status
  );

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> back_idle) else $error("result while back end busy");
  a_take_needs_req: assert property (@(posedge clk) disable iff (rst)
    req_take |-> req_valid) else $error("take without request");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3) else $error("bad status code");

endmodule
`default_nettype wire

### src/mlfq_front.sv
`default_nettype none
module mlfq_front #(
  parameter int unsigned QDEPTH = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [mlfq_pkg::OP_W-1:0]      op,
  input  wire logic [mlfq_pkg::TID_W-1:0]     thread_id,
  input  wire logic [mlfq_pkg::ELAPSED_W-1:0] elapsed_ms,
  output logic                               busy,
  output logic                               req_valid,
  output mlfq_pkg::req_t                     req,
  input  wire logic                          req_take
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  mlfq_pkg::req_t   fifo [QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign busy = (count == CW'(QDEPTH));
  assign push = start && !busy;
  assign req_valid = (count != '0);
  assign pop = req_valid && req_take;
  assign req = fifo[rd_ptr];

  // Requests are queued in arrival order for the back end.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
    if (push) begin
      fifo[wr_ptr] <= '{op: op, thread_id: thread_id, elapsed_ms: elapsed_ms};
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> !push) else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QDEPTH)) else $error("queue count overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");

endmodule
`default_nettype wire

### src/mlfq_back.sv
`default_nettype none
module mlfq_back #(
  parameter int unsigned LEVELS = 8,
  parameter int unsigned MAX_THREADS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          policy_mode,
  input  wire logic [mlfq_pkg::SLICE_W-1:0]   slice_ms,
  input  wire logic                          req_valid,
  input  wire mlfq_pkg::req_t                req,
  output logic                               req_take,
  output logic                               idle,
  output logic                               done,
  output logic [mlfq_pkg::TID_W-1:0]          running_tid,
  output logic                               running_valid,
  output logic                               switched,
  output logic [mlfq_pkg::TID_W-1:0]          created_tid,
  output logic [mlfq_pkg::SLICE_W-1:0]        grant_ms,
  output logic [mlfq_pkg::STATUS_W-1:0]       status
);

  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned TW = $clog2(MAX_THREADS);
  localparam int unsigned NW = $clog2(MAX_THREADS + 1);
  localparam int unsigned SW = mlfq_pkg::SLICE_LEFT_W;
  localparam int unsigned MW = LW + TW;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_CHOOSE, S_READ, S_POP, S_FIN
  } state_t;

  state_t                   state;
  mlfq_pkg::req_t           cur;
  logic                     pol;

  // Ready queue storage, one row per level.
  logic [TW-1:0]            qmem [LEVELS * MAX_THREADS];
  logic [TW-1:0]            qrd;
  logic [TW-1:0]            q_head [LEVELS];
  logic [TW-1:0]            q_tail [LEVELS];
  logic [NW-1:0]            q_count [LEVELS];

  // Per-thread state.
  logic [LW-1:0]            t_level [MAX_THREADS];
  logic signed [SW-1:0]     t_slice [MAX_THREADS];
  logic [1:0]               t_run [MAX_THREADS];

  logic [TW-1:0]            cur_tid;
  logic                     cur_valid;
  logic [NW-1:0]            total;
  logic [TW-1:0]            old_tid;
  logic                     old_valid;
  logic [TW-1:0]            created;
  logic [mlfq_pkg::STATUS_W-1:0] st;
  logic [LW-1:0]            pop_lvl;

  logic                     found;
  logic [LW-1:0]            first_lvl;
  logic [LW-1:0]            lvl_bump;
  logic signed [SW-1:0]     charged;
  logic [LW-1:0]            cur_level;

  assign req_take = (state == S_IDLE) && req_valid;
  assign idle = (state == S_IDLE);
  assign cur_level = t_level[cur_tid];

  // First non-empty level, over the LEVELS count flags.
  always_comb begin
    found = 1'b0;
    first_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (q_count[i] != '0) begin
        found = 1'b1;
        first_lvl = LW'(i);
      end
    end
  end

  // Level after an optional timeout demotion, and the charged slice.
  always_comb begin
    lvl_bump = cur_level;
    if (cur.op == mlfq_pkg::OP_TIMEOUT && cur_level < LW'(LEVELS - 1)) begin
      lvl_bump = cur_level + 1'b1;
    end
    charged = t_slice[cur_tid] - SW'(cur.elapsed_ms);
  end

  // Queue memory read port.
  always_ff @(posedge clk) begin
    qrd <= qmem[MW'({pop_lvl, q_head[pop_lvl]})];
  end

  // Sequencer: execute, choose, read, pop, report.
  always_ff @(posedge clk) begin
    logic [LW-1:0] pl;
    logic          do_push;
    logic [TW-1:0] ptid;
    logic          do_choose;
    state_t        nxt;
    pl = '0;
    do_push = 1'b0;
    ptid = '0;
    do_choose = 1'b0;
    nxt = state;
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      cur_tid <= '0;
      cur_valid <= 1'b1;
      total <= NW'(1);
      pol <= 1'b0;
      pop_lvl <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        q_head[i] <= '0;
        q_tail[i] <= '0;
        q_count[i] <= '0;
      end
      for (int i = 0; i < MAX_THREADS; i++) begin
        t_level[i] <= '0;
        t_run[i] <= mlfq_pkg::RUN_READY;
        t_slice[i] <= (i == 0) ? SW'(slice_ms) : '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            pol <= policy_mode;
            old_tid <= cur_tid;
            old_valid <= cur_valid;
            created <= '0;
            st <= mlfq_pkg::ST_OK;
            nxt = S_EXEC;
          end
        end
        S_EXEC: begin
          nxt = S_FIN;
          priority case (cur.op)
            mlfq_pkg::OP_CREATE: begin
              if (total >= NW'(MAX_THREADS)) begin
                st <= mlfq_pkg::ST_FULL;
              end else begin
                created <= TW'(total);
                t_level[TW'(total)] <= '0;
                t_slice[TW'(total)] <= SW'(slice_ms);
                t_run[TW'(total)] <= mlfq_pkg::RUN_READY;
                total <= total + 1'b1;
                do_push = 1'b1;
                pl = '0;
                ptid = TW'(total);
                if (!cur_valid) nxt = S_CHOOSE;
              end
            end
            mlfq_pkg::OP_YIELD, mlfq_pkg::OP_TIMEOUT,
            mlfq_pkg::OP_EXIT, mlfq_pkg::OP_BLOCK: begin
              if (cur_valid) begin
                if (cur.op == mlfq_pkg::OP_EXIT) begin
                  t_run[cur_tid] <= mlfq_pkg::RUN_EXITED;
                  cur_valid <= 1'b0;
                end
                if (cur.op == mlfq_pkg::OP_BLOCK) begin
                  t_run[cur_tid] <= mlfq_pkg::RUN_BLOCKED;
                  cur_valid <= 1'b0;
                end
                if (lvl_bump < LW'(LEVELS - 1) && charged <= 0) begin
                  t_level[cur_tid] <= lvl_bump + 1'b1;
                  t_slice[cur_tid] <= SW'(slice_ms);
                end else begin
                  t_level[cur_tid] <= lvl_bump;
                  if (lvl_bump < LW'(LEVELS - 1)) t_slice[cur_tid] <= charged;
                end
              end
              nxt = S_CHOOSE;
            end
            mlfq_pkg::OP_WAKE: begin
              if (NW'(cur.thread_id) >= total
                  || t_run[TW'(cur.thread_id)] != mlfq_pkg::RUN_BLOCKED) begin
                st <= mlfq_pkg::ST_BAD_WAKE;
              end else begin
                t_run[TW'(cur.thread_id)] <= mlfq_pkg::RUN_READY;
                do_push = 1'b1;
                pl = pol ? t_level[TW'(cur.thread_id)] : '0;
                ptid = TW'(cur.thread_id);
                if (!cur_valid) nxt = S_CHOOSE;
              end
            end
            default: begin
            end
          endcase
        end
        S_CHOOSE: begin
          nxt = S_FIN;
          if (pol) begin
            if (found) begin
              if (!cur_valid || first_lvl <= cur_level) begin
                if (cur_valid) begin
                  do_push = 1'b1;
                  pl = cur_level;
                  ptid = cur_tid;
                end
                do_choose = 1'b1;
                pop_lvl <= first_lvl;
              end
            end
          end else if (q_count[0] != '0) begin
            if (cur_valid) begin
              do_push = 1'b1;
              pl = '0;
              ptid = cur_tid;
            end
            do_choose = 1'b1;
            pop_lvl <= '0;
          end
          if (do_choose) nxt = S_READ;
        end
        S_READ: begin
          // The head entry of the chosen level is registered at the end of this cycle.
          nxt = S_POP;
        end
        S_POP: begin
          // The registered head entry becomes the running thread.
          nxt = S_FIN;
          cur_tid <= qrd;
          cur_valid <= 1'b1;
          q_head[pop_lvl] <= (q_head[pop_lvl] == TW'(MAX_THREADS - 1))
                             ? '0 : q_head[pop_lvl] + 1'b1;
          q_count[pop_lvl] <= q_count[pop_lvl] - 1'b1;
        end
        S_FIN: begin
          done <= 1'b1;
          nxt = S_IDLE;
        end
        default: nxt = S_IDLE;
      endcase
      state <= nxt;
      if (do_push && q_count[pl] < NW'(MAX_THREADS)) begin
        q_tail[pl] <= (q_tail[pl] == TW'(MAX_THREADS - 1)) ? '0 : q_tail[pl] + 1'b1;
        q_count[pl] <= q_count[pl] + 1'b1;
      end
    end
    if (!rst && do_push && q_count[pl] < NW'(MAX_THREADS)) begin
      qmem[MW'({pl, q_tail[pl]})] <= ptid;
    end
  end

  // Result fields, presented with the done strobe.
  always_comb begin
    logic signed [SW-1:0] s;
    s = t_slice[cur_tid];
    running_tid = cur_valid ? mlfq_pkg::TID_W'(cur_tid) : '0;
    running_valid = cur_valid;
    switched = (old_valid != cur_valid) || (cur_valid && old_tid != cur_tid);
    created_tid = mlfq_pkg::TID_W'(created);
    status = st;
    if (!cur_valid || s < 0) grant_ms = '0;
    else if (s > 1023) grant_ms = '1;
    else grant_ms = mlfq_pkg::SLICE_W'(s);
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == S_EXEC) else $error("request not started");
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double result");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |-> q_count[pop_lvl] != '0) else $error("pop from empty level");

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int NLEV = 8;
  localparam int NTHR = 32;
  localparam int STALL_LIMIT = 4000;

  // Expected outcome of one scheduling request.
  typedef struct {
    logic [mlfq_pkg::TID_W-1:0]    run_tid;
    logic                          run_on;
    logic                          sw;
    logic [mlfq_pkg::TID_W-1:0]    new_tid;
    logic [mlfq_pkg::SLICE_W-1:0]  grant;
    logic [mlfq_pkg::STATUS_W-1:0] st;
  } sched_out_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [mlfq_pkg::SLICE_W-1:0] cfg_data;
  logic start;
  logic busy;
  logic [mlfq_pkg::OP_W-1:0] op;
  logic [mlfq_pkg::TID_W-1:0] thread_id;
  logic [mlfq_pkg::ELAPSED_W-1:0] elapsed_ms;
  logic done;
  logic [mlfq_pkg::TID_W-1:0] running_tid;
  logic running_valid;
  logic switched;
  logic [mlfq_pkg::TID_W-1:0] created_tid;
  logic [mlfq_pkg::SLICE_W-1:0] grant_ms;
  logic [mlfq_pkg::STATUS_W-1:0] status;

  mlfq_thread_scheduler uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .op(op), .thread_id(thread_id), .elapsed_ms(elapsed_ms),
    .done(done), .running_tid(running_tid), .running_valid(running_valid),
    .switched(switched), .created_tid(created_tid), .grant_ms(grant_ms), .status(status)
  );

  // Requests waiting to be sent and outcomes waiting to be seen.
  mlfq_pkg::req_t pending_reqs[$];
  sched_out_t expected_outs[$];
  int errors = 0;

  // Scheduler state mirrored by the testbench.
  logic mode_mlfq;
  logic [mlfq_pkg::SLICE_W-1:0] slice_full;
  logic [mlfq_pkg::TID_W-1:0] rq_store [NLEV][NTHR];
  int rq_head [NLEV];
  int rq_tail [NLEV];
  int rq_cnt [NLEV];
  int lvl_of [NTHR];
  int slice_of [NTHR];
  logic [1:0] state_of [NTHR];
  int cur_tid;
  logic cur_on;
  int n_threads;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic rq_push(input int lv, input int t);
    if (rq_cnt[lv] < NTHR) begin
      rq_store[lv][rq_tail[lv]] = t[mlfq_pkg::TID_W-1:0];
      rq_tail[lv] = (rq_tail[lv] + 1) % NTHR;
      rq_cnt[lv]++;
    end
  endtask

  task automatic rq_pop(input int lv, output int t);
    t = rq_store[lv][rq_head[lv]];
    rq_head[lv] = (rq_head[lv] + 1) % NTHR;
    rq_cnt[lv]--;
  endtask

  // Pick the thread that runs next under the current policy.
  task automatic pick_next();
    int lv;
    int t;
    if (mode_mlfq) begin
      lv = NLEV;
      for (int i = NLEV - 1; i >= 0; i--) begin
        if (rq_cnt[i] > 0) lv = i;
      end
      if (cur_on) begin
        if (lv >= NLEV || lv > lvl_of[cur_tid]) return;
        rq_push(lvl_of[cur_tid], cur_tid);
      end
      if (lv < NLEV) begin
        rq_pop(lv, t);
        cur_tid = t;
        cur_on = 1'b1;
      end
    end else begin
      if (rq_cnt[0] == 0) return;
      if (cur_on) rq_push(0, cur_tid);
      rq_pop(0, t);
      cur_tid = t;
      cur_on = 1'b1;
    end
  endtask

  // Apply one request to the mirrored state and return the expected outcome.
  task automatic schedule_request(input mlfq_pkg::req_t r, output sched_out_t o);
    int old_tid;
    logic old_on;
    int t;
    old_tid = cur_tid;
    old_on = cur_on;
    o.new_tid = '0;
    o.st = mlfq_pkg::ST_OK;
    o.grant = '0;
    case (r.op)
      mlfq_pkg::OP_CREATE: begin
        if (n_threads >= NTHR) begin
          o.st = mlfq_pkg::ST_FULL;
        end else begin
          t = n_threads;
          n_threads++;
          o.new_tid = t[mlfq_pkg::TID_W-1:0];
          lvl_of[t] = 0;
          slice_of[t] = slice_full;
          state_of[t] = mlfq_pkg::RUN_READY;
          rq_push(0, t);
          if (!cur_on) pick_next();
        end
      end
      mlfq_pkg::OP_YIELD, mlfq_pkg::OP_TIMEOUT, mlfq_pkg::OP_EXIT, mlfq_pkg::OP_BLOCK: begin
        if (cur_on) begin
          t = cur_tid;
          if (r.op == mlfq_pkg::OP_TIMEOUT && lvl_of[t] < NLEV - 1) lvl_of[t]++;
          if (r.op == mlfq_pkg::OP_EXIT) begin
            state_of[t] = mlfq_pkg::RUN_EXITED;
            cur_on = 1'b0;
          end
          if (r.op == mlfq_pkg::OP_BLOCK) begin
            state_of[t] = mlfq_pkg::RUN_BLOCKED;
            cur_on = 1'b0;
          end
          // The lowest level is never charged.
          if (lvl_of[t] < NLEV - 1) begin
            slice_of[t] -= int'(r.elapsed_ms);
            if (slice_of[t] <= 0) begin
              lvl_of[t]++;
              slice_of[t] = slice_full;
            end
          end
        end
        pick_next();
      end
      mlfq_pkg::OP_WAKE: begin
        t = r.thread_id;
        if (t >= n_threads || state_of[t] != mlfq_pkg::RUN_BLOCKED) begin
          o.st = mlfq_pkg::ST_BAD_WAKE;
        end else begin
          state_of[t] = mlfq_pkg::RUN_READY;
          rq_push(mode_mlfq ? lvl_of[t] : 0, t);
          if (!cur_on) pick_next();
        end
      end
      default: begin
      end
    endcase
    if (cur_on) begin
      t = slice_of[cur_tid];
      o.grant = t < 0 ? '0 : (t > 1023 ? 10'd1023 : t[mlfq_pkg::SLICE_W-1:0]);
    end
    o.sw = (old_on != cur_on) || (cur_on && old_tid != cur_tid);
    o.run_tid = cur_on ? cur_tid[mlfq_pkg::TID_W-1:0] : '0;
    o.run_on = cur_on;
  endtask

  // Driver: sends queued requests in bursts separated by random gaps.
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin : driver
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) void'(pending_reqs.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        start <= 1'b1;
        op <= pending_reqs[0].op;
        thread_id <= pending_reqs[0].thread_id;
        elapsed_ms <= pending_reqs[0].elapsed_ms;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts each accepted request and checks each result strobe.
  int quiet_cycles = 0;
  always @(posedge clk) begin : monitor
    mlfq_pkg::req_t r;
    sched_out_t o;
    if (!rst) begin
      if (done) begin
        if (expected_outs.size() == 0) begin
          report_mismatch("unexpected result, running_tid", running_tid, 0);
        end else begin
          o = expected_outs.pop_front();
          if (running_tid !== o.run_tid) report_mismatch("running_tid", running_tid, o.run_tid);
          if (running_valid !== o.run_on)
            report_mismatch("running_valid", running_valid, o.run_on);
          if (switched !== o.sw) report_mismatch("switched", switched, o.sw);
          if (created_tid !== o.new_tid)
            report_mismatch("created_tid", created_tid, o.new_tid);
          if (grant_ms !== o.grant) report_mismatch("grant_ms", grant_ms, o.grant);
          if (status !== o.st) report_mismatch("status", status, o.st);
        end
      end
      if (start && !busy) begin
        r.op = op;
        r.thread_id = thread_id;
        r.elapsed_ms = elapsed_ms;
        schedule_request(r, o);
        expected_outs.push_back(o);
      end
      // Watchdog on requests or results that stop moving.
      if ((start && !busy) || done || (pending_reqs.size() == 0 && expected_outs.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic add_req(input logic [mlfq_pkg::OP_W-1:0] o, input int t, input int e);
    mlfq_pkg::req_t r;
    r.op = o;
    r.thread_id = t[mlfq_pkg::TID_W-1:0];
    r.elapsed_ms = e[mlfq_pkg::ELAPSED_W-1:0];
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(input logic idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[mlfq_pkg::SLICE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx) slice_full = val[mlfq_pkg::SLICE_W-1:0];
    else mode_mlfq = val[0];
  endtask

  task automatic wait_idle();
    wait (pending_reqs.size() == 0 && expected_outs.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  // Random mix weighted toward schedule events, block and wake.
  task automatic add_random(input int count);
    int k;
    int t;
    int e;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      t = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
      case ($urandom_range(0, 3))
        0: e = $urandom_range(0, 65535);
        1: e = $urandom_range(0, 3);
        default: e = $urandom_range(0, 2 * slice_full + 2);
      endcase
      if (k < 8) add_req(mlfq_pkg::OP_CREATE, t, e);
      else if (k < 33) add_req(mlfq_pkg::OP_YIELD, t, e);
      else if (k < 53) add_req(mlfq_pkg::OP_TIMEOUT, t, e);
      else if (k < 56) add_req(mlfq_pkg::OP_EXIT, t, e);
      else if (k < 74) add_req(mlfq_pkg::OP_BLOCK, t, e);
      else if (k < 97) add_req(mlfq_pkg::OP_WAKE, t, e);
      else add_req(3'($urandom_range(6, 7)), t, e);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    start = 1'b0;
    op = '0;
    thread_id = '0;
    elapsed_ms = '0;
    // Mirror of the reset state: thread 0 runs with a full slice.
    mode_mlfq = 1'b1;
    slice_full = 10'd10;
    for (int l = 0; l < NLEV; l++) begin
      rq_head[l] = 0;
      rq_tail[l] = 0;
      rq_cnt[l] = 0;
      for (int i = 0; i < NTHR; i++) rq_store[l][i] = '0;
    end
    for (int i = 0; i < NTHR; i++) begin
      lvl_of[i] = 0;
      slice_of[i] = 0;
      state_of[i] = mlfq_pkg::RUN_READY;
    end
    slice_of[0] = 10;
    cur_tid = 0;
    cur_on = 1'b1;
    n_threads = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: invalid wakes, creates, charging extremes, idle and unknown ops.
    add_req(mlfq_pkg::OP_WAKE, 31, 0);
    add_req(mlfq_pkg::OP_WAKE, 0, 0);
    add_req(mlfq_pkg::OP_YIELD, 0, 0);
    add_req(mlfq_pkg::OP_CREATE, 0, 0);
    add_req(mlfq_pkg::OP_CREATE, 31, 65535);
    add_req(mlfq_pkg::OP_TIMEOUT, 0, 3);
    add_req(mlfq_pkg::OP_YIELD, 0, 65535);
    add_req(mlfq_pkg::OP_BLOCK, 0, 4);
    add_req(mlfq_pkg::OP_WAKE, 1, 0);
    add_req(mlfq_pkg::OP_WAKE, 0, 0);
    add_req(mlfq_pkg::OP_BLOCK, 0, 1);
    add_req(mlfq_pkg::OP_BLOCK, 0, 1);
    add_req(mlfq_pkg::OP_BLOCK, 0, 1);
    add_req(mlfq_pkg::OP_YIELD, 0, 7);
    add_req(mlfq_pkg::OP_WAKE, 2, 0);
    add_req(mlfq_pkg::OP_EXIT, 0, 10);
    add_req(3'd6, 5, 1);
    add_req(3'd7, 26, 65534);
    for (int i = 0; i < 6; i++) add_req(mlfq_pkg::OP_TIMEOUT, 0, 32768);
    wait_idle();

    // Random phases across the policy and slice settings, extremes included.
    write_reg(1'b0, 1);
    write_reg(1'b1, 1000);
    add_random(300);
    wait_idle();
    write_reg(1'b0, 0);
    write_reg(1'b1, 1);
    add_random(300);
    wait_idle();
    write_reg(1'b0, 1);
    write_reg(1'b1, 0);
    add_random(300);
    wait_idle();
    write_reg(1'b0, 0);
    write_reg(1'b1, 1023);
    add_random(300);
    wait_idle();
    write_reg(1'b0, 1);
    write_reg(1'b1, $urandom_range(2, 60));
    add_random(300);
    wait_idle();
    write_reg(1'b1, $urandom_range(1, 1000));
    add_random(300);

    wait (pending_reqs.size() == 0 && expected_outs.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
